FILE: rtl/cmdu_pkg.sv
// Shared types and constants for the cascadable multiply/divide unit.
`timescale 1ns / 1ps

package cmdu_pkg;

    // Bus command codes carried in tuser
    typedef enum logic [3:0] {
        CMD_WR_X    = 4'd0,
        CMD_WR_Y    = 4'd1,
        CMD_WR_Z    = 4'd2,
        CMD_CONTROL = 4'd3,
        CMD_RD_X    = 4'd4,
        CMD_RD_Y    = 4'd5,
        CMD_RD_Z    = 4'd6,
        CMD_STATUS  = 4'd7,
        CMD_TICK    = 4'd8
    } t_cmd;

    typedef enum logic [1:0] {
        OP_NONE    = 2'd0,
        OP_MUL     = 2'd1,
        OP_DIV     = 2'd2,
        OP_ILLEGAL = 2'd3
    } t_op;

    // Control word bit positions
    localparam int CTL_CLR_Z    = 2;
    localparam int CTL_CLR_Y    = 3;
    localparam int CTL_SLICE_LO = 4;
    localparam int CTL_SLICE_HI = 5;
    localparam int CTL_PTR_RST  = 6;
    localparam int CTL_PRESCALE = 7;

    localparam int CNT_W = 9;

    // Countdown loads, indexed by slice count minus one
    localparam logic [CNT_W-1:0] PLAIN_TICKS [4] = '{9'd9, 9'd17, 9'd25, 9'd33};
    localparam logic [CNT_W-1:0] SCALED_TICKS [4] = '{9'd18, 9'd68, 9'd200, 9'd264};

    typedef struct packed {
        logic       valid;
        logic       op_div;
        logic [2:0] slices;
    } t_start;

    typedef struct packed {
        logic [1:0] idx_a;   // X and Y byte
        logic [1:0] idx_b;   // Z byte
    } t_rd_req;

    typedef struct packed {
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] z;
    } t_rd_bytes;

    typedef struct packed {
        logic       we;
        logic       to_y;
        logic [1:0] idx;
        logic [7:0] data;
    } t_wb;

endpackage

FILE: rtl/cascadable_multiply_divide_unit.sv
// Top level of the cascadable multiply/divide unit: stream ports and result register.
`timescale 1ns / 1ps

// One to MAX_SLICES 8-bit slices behind X, Y and Z bus registers. Each input word
// is one bus command and gives one result word. The tick that ends a multiply or
// divide runs the bit-serial engine, which reads the operands a byte per cycle,
// does one bit per cycle and writes back a byte per cycle. A divide by zero ends
// after the operand load and the zero check, with no loop and no write-back.
// A result waiting on the output does not stop the next word being taken.

module cascadable_multiply_divide_unit #(
    parameter int MAX_SLICES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_in
    input  logic [3:0]  s_axis_tuser,   // [3:0] cmd
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata    // [7:0] read_data, [8] overflow, [9] busy_res
);

    cmdu_pkg::t_rd_req   rd_req;
    cmdu_pkg::t_rd_bytes rd_bytes;
    cmdu_pkg::t_wb       wb;
    cmdu_pkg::t_start    start;
    logic                ovf_set;
    logic                eng_busy;
    logic [7:0]          rd_data;
    logic                ovf;
    logic                busy;
    logic                fire;
    logic                load_out;

    logic                r_pend;
    logic [7:0]          r_rd;
    logic                r_m_valid;
    logic [9:0]          r_m_data;

    cmdu_regs #(
        .MAX_SLICES (MAX_SLICES)
    ) u_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (fire),
        .i_cmd      (s_axis_tuser),
        .i_data     (s_axis_tdata),
        .i_rd_req   (rd_req),
        .o_rd_bytes (rd_bytes),
        .i_wb       (wb),
        .i_ovf_set  (ovf_set),
        .o_start    (start),
        .o_rd_data  (rd_data),
        .o_ovf      (ovf),
        .o_busy     (busy)
    );

    cmdu_engine #(
        .MAX_SLICES (MAX_SLICES)
    ) u_engine (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (start),
        .o_rd_req  (rd_req),
        .i_bytes   (rd_bytes),
        .o_wb      (wb),
        .o_ovf_set (ovf_set),
        .o_busy    (eng_busy)
    );

    assign s_axis_tready = !r_pend && !eng_busy;
    assign fire          = s_axis_tvalid && s_axis_tready;
    // status is taken once the engine has written back
    assign load_out      = r_pend && !eng_busy && (!r_m_valid || m_axis_tready);

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {6'd0, r_m_data};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend    <= 1'b0;
            r_m_valid <= 1'b0;
        end else begin
            if (fire) begin
                r_pend <= 1'b1;
            end else if (load_out) begin
                r_pend <= 1'b0;
            end
            if (load_out) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_rd <= rd_data;
        end
        if (load_out) begin
            r_m_data <= {busy, ovf, r_rd};
        end
    end

    a_start_holds_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        start.valid |=> (eng_busy && r_pend && !s_axis_tready))
        else $error("word not held while operation runs");

endmodule

FILE: rtl/cmdu_regs.sv
// Bus register file: X/Y/Z bytes, byte pointer, control, countdown and overflow.
`timescale 1ns / 1ps

module cmdu_regs #(
    parameter int MAX_SLICES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_fire,
    input  logic [3:0]          i_cmd,
    input  logic [7:0]          i_data,
    input  cmdu_pkg::t_rd_req   i_rd_req,
    output cmdu_pkg::t_rd_bytes o_rd_bytes,
    input  cmdu_pkg::t_wb       i_wb,
    input  logic                i_ovf_set,
    output cmdu_pkg::t_start    o_start,
    output logic [7:0]          o_rd_data,
    output logic                o_ovf,
    output logic                o_busy
);

    logic [7:0]                  r_x [MAX_SLICES];
    logic [7:0]                  r_y [MAX_SLICES];
    logic [7:0]                  r_z [MAX_SLICES];
    logic [1:0]                  r_ptr;
    logic [2:0]                  r_slices;
    cmdu_pkg::t_op               r_op;
    logic [cmdu_pkg::CNT_W-1:0]  r_cnt;
    logic                        r_ovf;

    cmdu_pkg::t_cmd              cmd;
    logic [2:0]                  ptr_inc;
    logic [1:0]                  ptr_next;
    logic [7:0]                  x_at, y_at, z_at;
    logic [2:0]                  sl_raw, sl_new;
    logic [1:0]                  sl_idx;
    logic                        complete;

    always_comb begin
        cmd      = cmdu_pkg::t_cmd'(i_cmd);
        ptr_inc  = {1'b0, r_ptr} + 3'd1;
        ptr_next = (ptr_inc >= r_slices) ? 2'd0 : ptr_inc[1:0];

        x_at = 8'd0;
        y_at = 8'd0;
        z_at = 8'd0;
        o_rd_bytes = '0;
        for (int i = 0; i < MAX_SLICES; i++) begin
            if (r_ptr == 2'(i)) begin
                x_at = r_x[i];
                y_at = r_y[i];
                z_at = r_z[i];
            end
            if (i_rd_req.idx_a == 2'(i)) begin
                o_rd_bytes.x = r_x[i];
                o_rd_bytes.y = r_y[i];
            end
            if (i_rd_req.idx_b == 2'(i)) begin
                o_rd_bytes.z = r_z[i];
            end
        end

        // slice field is stored inverted
        sl_raw = {1'b0, ~i_data[cmdu_pkg::CTL_SLICE_HI:cmdu_pkg::CTL_SLICE_LO]} + 3'd1;
        sl_new = (sl_raw > 3'(MAX_SLICES)) ? 3'(MAX_SLICES) : sl_raw;
        sl_idx = 2'(sl_new - 3'd1);

        unique case (cmd) inside
            cmdu_pkg::CMD_RD_X:   o_rd_data = x_at;
            cmdu_pkg::CMD_RD_Y:   o_rd_data = y_at;
            cmdu_pkg::CMD_RD_Z:   o_rd_data = z_at;
            cmdu_pkg::CMD_STATUS: o_rd_data = {7'd0, r_ovf};
            default:              o_rd_data = 8'd0;
        endcase

        complete       = i_fire && (cmd == cmdu_pkg::CMD_TICK) &&
                         (r_cnt == cmdu_pkg::CNT_W'(1));
        o_start.valid  = complete &&
                         (r_op == cmdu_pkg::OP_MUL || r_op == cmdu_pkg::OP_DIV);
        o_start.op_div = (r_op == cmdu_pkg::OP_DIV);
        o_start.slices = r_slices;
    end

    assign o_ovf  = r_ovf;
    assign o_busy = (r_cnt != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < MAX_SLICES; i++) begin
                r_x[i] <= 8'd0;
                r_y[i] <= 8'd0;
                r_z[i] <= 8'd0;
            end
            r_ptr    <= 2'd0;
            r_slices <= 3'd1;
            r_op     <= cmdu_pkg::OP_NONE;
            r_cnt    <= '0;
            r_ovf    <= 1'b0;
        end else begin
            if (i_ovf_set) begin
                r_ovf <= 1'b1;
            end
            if (i_wb.we) begin
                for (int i = 0; i < MAX_SLICES; i++) begin
                    if (i_wb.idx == 2'(i)) begin
                        if (i_wb.to_y) begin
                            r_y[i] <= i_wb.data;
                        end else begin
                            r_z[i] <= i_wb.data;
                        end
                    end
                end
            end
            if (i_fire) begin
                unique case (cmd) inside
                    cmdu_pkg::CMD_WR_X, cmdu_pkg::CMD_WR_Y, cmdu_pkg::CMD_WR_Z: begin
                        for (int i = 0; i < MAX_SLICES; i++) begin
                            if (r_ptr == 2'(i)) begin
                                if (cmd == cmdu_pkg::CMD_WR_X) r_x[i] <= i_data;
                                if (cmd == cmdu_pkg::CMD_WR_Y) r_y[i] <= i_data;
                                if (cmd == cmdu_pkg::CMD_WR_Z) r_z[i] <= i_data;
                            end
                        end
                        r_ptr <= ptr_next;
                    end
                    cmdu_pkg::CMD_RD_X, cmdu_pkg::CMD_RD_Y, cmdu_pkg::CMD_RD_Z: begin
                        r_ptr <= ptr_next;
                    end
                    cmdu_pkg::CMD_CONTROL: begin
                        r_op <= cmdu_pkg::t_op'(i_data[1:0]);
                        // clears span the old slice count
                        for (int i = 0; i < MAX_SLICES; i++) begin
                            if (3'(i) < r_slices) begin
                                if (i_data[cmdu_pkg::CTL_CLR_Z]) r_z[i] <= 8'd0;
                                if (i_data[cmdu_pkg::CTL_CLR_Y]) r_y[i] <= 8'd0;
                            end
                        end
                        r_slices <= sl_new;
                        if (i_data[cmdu_pkg::CTL_PTR_RST]) begin
                            r_ptr <= 2'd0;
                        end
                        r_ovf <= 1'b0;
                        r_cnt <= i_data[cmdu_pkg::CTL_PRESCALE] ?
                                 cmdu_pkg::SCALED_TICKS[sl_idx] :
                                 cmdu_pkg::PLAIN_TICKS[sl_idx];
                    end
                    cmdu_pkg::CMD_TICK: begin
                        if (r_cnt != '0) begin
                            r_cnt <= r_cnt - cmdu_pkg::CNT_W'(1);
                            if (r_cnt == cmdu_pkg::CNT_W'(1)) begin
                                r_op <= cmdu_pkg::OP_NONE;
                            end
                        end
                    end
                    default: ;
                endcase
            end
        end
    end

    // an expired countdown never leaves an operation armed
    a_idle_no_op: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> (r_op == cmdu_pkg::OP_NONE))
        else $error("operation pending with countdown expired");

endmodule

FILE: rtl/cmdu_engine.sv
// Bit-serial multiply/divide engine with byte-serial operand load and write-back.
`timescale 1ns / 1ps

module cmdu_engine #(
    parameter int MAX_SLICES = 4
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  cmdu_pkg::t_start    i_start,
    output cmdu_pkg::t_rd_req   o_rd_req,
    input  cmdu_pkg::t_rd_bytes i_bytes,
    output cmdu_pkg::t_wb       o_wb,
    output logic                o_ovf_set,
    output logic                o_busy
);

    localparam int MW = 8 * MAX_SLICES;
    localparam int CW = $clog2(2 * MW);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_LOAD  = 6'b000010,
        S_CHECK = 6'b000100,
        S_MUL   = 6'b001000,
        S_DIV   = 6'b010000,
        S_WBACK = 6'b100000
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_cnt;
    logic [2:0]      r_n;
    logic            r_div;
    logic [MW-1:0]   r_x;
    logic [MW:0]     r_acc;      // partial product high half, or partial remainder
    logic [2*MW-1:0] r_s;        // divide: {Y, Z left-aligned}; multiply: low half holds Z

    logic [CW-1:0]   n_ext;
    logic [2:0]      k3, kk;
    logic            in_y_half;
    logic [MW:0]     mul_sum;
    logic [MW:0]     div_sh, div_diff;
    logic            div_ge;
    logic            last_load, last_mul, last_div, last_wb;

    always_comb begin
        n_ext     = CW'(r_n);
        k3        = r_cnt[2:0];
        in_y_half = (k3 >= r_n);
        kk        = in_y_half ? (k3 - r_n) : k3;

        o_rd_req.idx_a = r_cnt[1:0];
        // Z goes in least significant byte first when it is left-aligned
        o_rd_req.idx_b = r_div ? (r_n[1:0] - 2'd1 - r_cnt[1:0]) : r_cnt[1:0];

        mul_sum  = r_acc + (r_s[0] ? {1'b0, r_x} : '0);
        div_sh   = {r_acc[MW-1:0], r_s[2*MW-1]};
        div_ge   = (div_sh >= {1'b0, r_x});
        div_diff = div_sh - {1'b0, r_x};

        last_load = (r_cnt == n_ext - CW'(1));
        last_mul  = (r_cnt == CW'(MW - 1));
        last_div  = (r_cnt == CW'(MW - 1) + (n_ext << 3));
        last_wb   = (r_cnt == (n_ext << 1) - CW'(1));

        o_wb.we   = (r_state == S_WBACK);
        o_wb.to_y = in_y_half;
        o_wb.idx  = r_n[1:0] - 2'd1 - kk[1:0];
        o_wb.data = (r_div && in_y_half) ? r_acc[7:0] : r_s[7:0];

        o_ovf_set = (r_state == S_CHECK) && r_div && (r_x <= r_s[2*MW-1:MW]);
        o_busy    = (r_state != S_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_start.valid) begin
                        r_div   <= i_start.op_div;
                        r_n     <= i_start.slices;
                        r_cnt   <= '0;
                        r_x     <= '0;
                        r_acc   <= '0;
                        r_s     <= '0;
                        r_state <= S_LOAD;
                    end
                end
                S_LOAD: begin
                    r_x <= (r_x << 8) | MW'(i_bytes.x);
                    if (r_div) begin
                        r_s[2*MW-1:MW] <= (r_s[2*MW-1:MW] << 8) | MW'(i_bytes.y);
                        r_s[MW-1:0]    <= (r_s[MW-1:0] >> 8) | (MW'(i_bytes.z) << (MW - 8));
                    end else begin
                        r_acc       <= (r_acc << 8) | (MW+1)'(i_bytes.y);
                        r_s[MW-1:0] <= (r_s[MW-1:0] << 8) | MW'(i_bytes.z);
                    end
                    if (last_load) begin
                        r_cnt   <= '0;
                        r_state <= S_CHECK;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_CHECK: begin
                    r_cnt <= '0;
                    if (!r_div) begin
                        r_state <= S_MUL;
                    end else if (r_x == '0) begin
                        r_state <= S_IDLE;     // divide by zero: Y and Z left alone
                    end else begin
                        r_state <= S_DIV;
                    end
                end
                S_MUL: begin
                    r_acc       <= mul_sum >> 1;
                    r_s[MW-1:0] <= {mul_sum[0], r_s[MW-1:1]};
                    if (last_mul) begin
                        r_cnt   <= '0;
                        r_state <= S_WBACK;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_DIV: begin
                    r_acc <= div_ge ? div_diff : div_sh;
                    r_s   <= {r_s[2*MW-2:0], div_ge};
                    if (last_div) begin
                        r_cnt   <= '0;
                        r_state <= S_WBACK;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                S_WBACK: begin
                    if (!r_div) begin
                        // product sits in {acc, low half}: shift the pair a byte
                        r_s[MW-1:0] <= (r_s[MW-1:0] >> 8) | (MW'(r_acc[7:0]) << (MW - 8));
                        r_acc       <= r_acc >> 8;
                    end else if (!in_y_half) begin
                        r_s[MW-1:0] <= r_s[MW-1:0] >> 8;
                    end else begin
                        r_acc <= r_acc >> 8;
                    end
                    if (last_wb) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_acc < {1'b0, r_x}))
        else $error("partial remainder not below divisor");

    a_mul_no_carry_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> !r_acc[MW])
        else $error("multiply accumulator carried past its width");

endmodule
